// ===== rtl/core/frsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the frame rate statistics monitor.
package frsm_pkg;

  // Field widths fixed by the interface.
  localparam int RateW  = 20;
  localparam int TickW  = 32;
  localparam int DrawW  = 32;
  localparam int AmtW   = 16;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // Default width of the saturating sums.
  localparam int SumWidthDef = 48;

  // Register values after reset.
  localparam logic [RateW-1:0] TickRateReset = RateW'(1000000);
  localparam logic [TickW-1:0] AvgIntervalReset = TickW'(1000000);

  // Register indexes, taken from the word address.
  typedef enum logic [1:0] {
    REG_TICK_RATE   = 2'd0,
    REG_AVG_INTERVAL = 2'd1,
    REG_EVENTS_EN   = 2'd2
  } reg_idx_e;

  // Input word commands.
  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_ACCUM,
    ST_CHECK,
    ST_AVG_RATE,
    ST_AVG_TICKS,
    ST_OUT
  } state_e;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_SEL_RATE,
    DIV_SEL_AVG_RATE,
    DIV_SEL_AVG_TICKS
  } div_sel_e;

  // Control towards the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status back from the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/frame_rate_statistics_monitor.sv =====
`timescale 1ns / 1ps
// Top level of the frame rate statistics monitor: registers, sequencer and statistics.
//
//  Channel  Direction  Handshake               Words
//  in       input      in_valid_i / in_stall_o  mode_i, timestamp_i, draw_amount_i
//  out      output     out_valid_o / out_stall_i frame statistics, one per frame mark
//  cfg      input      APB psel/penable/pwrite  tick_rate, average_interval, events_enabled
//
// Draw commands are handled in the idle state. A frame mark takes one division
// for its rate, and two more for the averages when it closes an averaging interval;
// the serial divider gives one quotient bit per cycle over SUM_WIDTH bits.
// Reset is asynchronous, active low; all statistics restart from their reset
// values. A stalled output word is held, and the next input word is taken meanwhile.
module frame_rate_statistics_monitor #(
  parameter int SUM_WIDTH = frsm_pkg::SumWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [frsm_pkg::TickW-1:0]  timestamp_i,
  input  logic [frsm_pkg::AmtW-1:0]   draw_amount_i,
  // Output channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [frsm_pkg::DrawW-1:0]  draw_total_o,
  output logic [frsm_pkg::TickW-1:0]  frame_ticks_o,
  output logic [frsm_pkg::TickW-1:0]  frame_ticks_avg_o,
  output logic [frsm_pkg::RateW-1:0]  rate_o,
  output logic [frsm_pkg::RateW-1:0]  rate_min_o,
  output logic [frsm_pkg::RateW-1:0]  rate_max_o,
  output logic [frsm_pkg::RateW-1:0]  rate_avg_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frsm_pkg::AddrW-1:0]  paddr,
  input  logic [frsm_pkg::DataW-1:0]  pwdata,
  output logic [frsm_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import frsm_pkg::*;

  localparam int SumExtW = SUM_WIDTH + 1;

  // Configuration registers.
  logic [RateW-1:0] tick_rate_q;
  logic [TickW-1:0] avg_interval_q;
  logic             events_en_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  // Sequencer.
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_free;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  div_sel_e  div_sel;
  logic [SUM_WIDTH-1:0] div_dividend;
  logic [TickW-1:0]     div_divisor;
  logic [SUM_WIDTH-1:0] div_quo;

  // Statistics state.
  logic [TickW-1:0]     last_frame_q;
  logic [TickW-1:0]     last_avg_q;
  logic [DrawW-1:0]     draw_cnt_q;
  logic [RateW-1:0]     min_rate_q;
  logic [RateW-1:0]     max_rate_q;
  logic [RateW-1:0]     avg_rate_q;
  logic [SUM_WIDTH-1:0] rate_sum_q;
  logic [SUM_WIDTH-1:0] ticks_sum_q;
  logic [TickW-1:0]     sample_cnt_q;
  logic [TickW-1:0]     avg_ticks_q;

  // Per-frame working registers.
  logic [TickW-1:0] ts_q;
  logic [TickW-1:0] delta_q;
  logic [RateW-1:0] rate_q;
  logic             avg_due_q;
  logic [TickW-1:0] delta_in;
  logic [TickW-1:0] since;
  logic [SumExtW-1:0] rate_sum_ext;
  logic [SumExtW-1:0] ticks_sum_ext;

  // Output register.
  logic             out_valid_q;
  logic [DrawW-1:0] o_draw_q;
  logic [TickW-1:0] o_ticks_q;
  logic [TickW-1:0] o_ticks_avg_q;
  logic [RateW-1:0] o_rate_q;
  logic [RateW-1:0] o_min_q;
  logic [RateW-1:0] o_max_q;
  logic [RateW-1:0] o_avg_q;

  // Configuration write and read.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q    <= TickRateReset;
      avg_interval_q <= AvgIntervalReset;
      events_en_q    <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TICK_RATE:    tick_rate_q    <= pwdata[RateW-1:0];
        REG_AVG_INTERVAL: avg_interval_q <= pwdata[TickW-1:0];
        REG_EVENTS_EN:    events_en_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TICK_RATE:    prdata = DataW'(tick_rate_q);
      REG_AVG_INTERVAL: prdata = DataW'(avg_interval_q);
      REG_EVENTS_EN:    prdata = DataW'(events_en_q);
      default:          prdata = '0;
    endcase
  end

  // Handshake terms.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign delta_in   = timestamp_i - last_frame_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (mode_i == MODE_FRAME)) state_d = ST_RATE;
      end
      ST_RATE: begin
        if (div_stat.done) state_d = ST_ACCUM;
      end
      ST_ACCUM: state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = avg_due_q ? ST_AVG_RATE : ST_OUT;
      end
      ST_AVG_RATE: begin
        if (div_stat.done) state_d = ST_AVG_TICKS;
      end
      ST_AVG_TICKS: begin
        if (div_stat.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider start and operand choice.
  always_comb begin
    div_ctrl.start = 1'b0;
    div_sel        = DIV_SEL_RATE;
    case (state_q)
      ST_IDLE: begin
        div_ctrl.start = in_acc && (mode_i == MODE_FRAME);
      end
      ST_CHECK: begin
        div_ctrl.start = avg_due_q;
        div_sel        = DIV_SEL_AVG_RATE;
      end
      ST_AVG_RATE: begin
        div_ctrl.start = div_stat.done;
        div_sel        = DIV_SEL_AVG_TICKS;
      end
      default: ;
    endcase
  end

  // Divider operands.
  always_comb begin
    case (div_sel)
      DIV_SEL_RATE: begin
        div_dividend = SUM_WIDTH'(tick_rate_q);
        div_divisor  = delta_in;
      end
      DIV_SEL_AVG_RATE: begin
        div_dividend = rate_sum_q;
        div_divisor  = sample_cnt_q;
      end
      DIV_SEL_AVG_TICKS: begin
        div_dividend = ticks_sum_q;
        div_divisor  = sample_cnt_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  frsm_div #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Saturating sums and interval check.
  assign rate_sum_ext  = {1'b0, rate_sum_q} + SumExtW'(rate_q);
  assign ticks_sum_ext = {1'b0, ticks_sum_q} + SumExtW'(delta_q);
  assign since         = ts_q - last_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Statistics state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_frame_q <= '0;
      last_avg_q   <= '0;
      draw_cnt_q   <= '0;
      min_rate_q   <= '1;
      max_rate_q   <= '0;
      avg_rate_q   <= '0;
      rate_sum_q   <= '0;
      ticks_sum_q  <= '0;
      sample_cnt_q <= '0;
      avg_ticks_q  <= '0;
      avg_due_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (mode_i)
              MODE_FRAME: last_frame_q <= timestamp_i;
              MODE_ADD: begin
                if (events_en_q) draw_cnt_q <= draw_cnt_q + DrawW'(draw_amount_i);
              end
              MODE_CLEAR: draw_cnt_q <= '0;
              default: ;
            endcase
          end
        end
        ST_ACCUM: begin
          if (rate_q < min_rate_q) min_rate_q <= rate_q;
          if (rate_q > max_rate_q) max_rate_q <= rate_q;
          rate_sum_q  <= rate_sum_ext[SUM_WIDTH] ? '1 : rate_sum_ext[SUM_WIDTH-1:0];
          ticks_sum_q <= ticks_sum_ext[SUM_WIDTH] ? '1 : ticks_sum_ext[SUM_WIDTH-1:0];
          if (sample_cnt_q != '1) sample_cnt_q <= sample_cnt_q + 1'b1;
          avg_due_q <= since >= avg_interval_q;
        end
        ST_AVG_RATE: begin
          if (div_stat.done) avg_rate_q <= div_quo[RateW-1:0];
        end
        ST_AVG_TICKS: begin
          // Close the interval once both averages are formed.
          if (div_stat.done) begin
            avg_ticks_q  <= div_quo[TickW-1:0];
            last_avg_q   <= ts_q;
            rate_sum_q   <= '0;
            ticks_sum_q  <= '0;
            sample_cnt_q <= '0;
            min_rate_q   <= '1;
            max_rate_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-frame working registers; a zero delta gives the full tick rate.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      ts_q    <= timestamp_i;
      delta_q <= delta_in;
    end
    if (state_q == ST_RATE && div_stat.done) begin
      rate_q <= (delta_q == '0) ? tick_rate_q : div_quo[RateW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      o_draw_q      <= draw_cnt_q;
      o_ticks_q     <= delta_q;
      o_ticks_avg_q <= avg_ticks_q;
      o_rate_q      <= rate_q;
      o_min_q       <= min_rate_q;
      o_max_q       <= max_rate_q;
      o_avg_q       <= avg_rate_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign draw_total_o      = o_draw_q;
  assign frame_ticks_o     = o_ticks_q;
  assign frame_ticks_avg_o = o_ticks_avg_q;
  assign rate_o            = o_rate_q;
  assign rate_min_o        = o_min_q;
  assign rate_max_o        = o_max_q;
  assign rate_avg_o        = o_avg_q;

endmodule

// ===== rtl/core/frsm_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
module frsm_div #(
  parameter int SUM_WIDTH = frsm_pkg::SumWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  frsm_pkg::div_ctrl_t       ctrl_i,
  input  logic [SUM_WIDTH-1:0]      dividend_i,
  input  logic [frsm_pkg::TickW-1:0] divisor_i,
  output frsm_pkg::div_stat_t       stat_o,
  output logic [SUM_WIDTH-1:0]      quotient_o
);
  import frsm_pkg::*;

  localparam int CntW = $clog2(SUM_WIDTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(SUM_WIDTH - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [TickW-1:0]     rem_q, rem_d;
  logic [SUM_WIDTH-1:0] quo_q, quo_d;
  logic [TickW-1:0]     dsr_q, dsr_d;
  logic [TickW:0]       trial;
  logic                 fits;

  // One trial subtraction of the partial remainder.
  assign trial = {rem_q, quo_q[SUM_WIDTH-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  // Iteration step and operand load.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (busy_q) begin
      if (fits) begin
        rem_d = TickW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[TickW-1:0];
      end
      quo_d = {quo_q[SUM_WIDTH-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = LastCnt;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end
  end

  // Control flops.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath flops.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== test/frsm_stats_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame rate statistics monitor: predicts and compares every result word.
module frsm_stats_checker #(
  parameter int SumW = frsm_pkg::SumWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic [1:0]                  mode_i,
  input  logic [frsm_pkg::TickW-1:0]  timestamp_i,
  input  logic [frsm_pkg::AmtW-1:0]   draw_amount_i,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [frsm_pkg::DrawW-1:0]  draw_total_o,
  input  logic [frsm_pkg::TickW-1:0]  frame_ticks_o,
  input  logic [frsm_pkg::TickW-1:0]  frame_ticks_avg_o,
  input  logic [frsm_pkg::RateW-1:0]  rate_o,
  input  logic [frsm_pkg::RateW-1:0]  rate_min_o,
  input  logic [frsm_pkg::RateW-1:0]  rate_max_o,
  input  logic [frsm_pkg::RateW-1:0]  rate_avg_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frsm_pkg::AddrW-1:0]  paddr,
  input  logic [frsm_pkg::DataW-1:0]  pwdata,
  input  logic                        pready,
  output int                          errors_o,
  output int                          waiting_o
);
  import frsm_pkg::*;

  // Statistics carried by one result word.
  typedef struct packed {
    logic [DrawW-1:0] draws;
    logic [TickW-1:0] ticks;
    logic [TickW-1:0] ticks_avg;
    logic [RateW-1:0] rate;
    logic [RateW-1:0] rate_min;
    logic [RateW-1:0] rate_max;
    logic [RateW-1:0] rate_avg;
  } frame_stats_t;

  // Shadow copy of the registers, following the configuration port.
  logic [RateW-1:0] tick_rate;
  logic [TickW-1:0] avg_interval;
  logic             events_on;

  // Shadow copy of the statistics state.
  logic [TickW-1:0] last_mark;
  logic [TickW-1:0] last_avg_mark;
  logic [DrawW-1:0] draw_tally;
  logic [RateW-1:0] lowest_rate;
  logic [RateW-1:0] highest_rate;
  logic [RateW-1:0] mean_rate;
  logic [SumW-1:0]  rate_sum;
  logic [SumW-1:0]  ticks_sum;
  logic [31:0]      frame_count;
  logic [TickW-1:0] mean_ticks;

  frame_stats_t frames_q[$];
  int           err_cnt;

  assign errors_o = err_cnt;

  // Sum that sticks at all-ones instead of wrapping.
  function automatic logic [SumW-1:0] add_clamped(logic [SumW-1:0] acc, logic [SumW-1:0] add);
    logic [SumW:0] total;
    total = {1'b0, acc} + {1'b0, add};
    return total[SumW] ? '1 : total[SumW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Apply one accepted input word to the shadow state and queue any result it causes.
  task automatic track_word(logic [1:0] m, logic [TickW-1:0] ts, logic [AmtW-1:0] amt);
    logic [TickW-1:0] delta;
    logic [TickW-1:0] since;
    logic [RateW-1:0] rate;
    frame_stats_t     want;
    case (m)
      MODE_ADD: begin
        if (events_on) draw_tally = draw_tally + DrawW'(amt);
      end
      MODE_CLEAR: begin
        draw_tally = '0;
      end
      MODE_FRAME: begin
        delta = ts - last_mark;
        last_mark = ts;
        // A repeated timestamp gives the full tick rate rather than a division by zero.
        rate = (delta == '0) ? tick_rate : RateW'(TickW'(tick_rate) / delta);
        if (rate < lowest_rate) lowest_rate = rate;
        if (rate > highest_rate) highest_rate = rate;
        rate_sum = add_clamped(rate_sum, SumW'(rate));
        ticks_sum = add_clamped(ticks_sum, SumW'(delta));
        if (frame_count != '1) frame_count++;
        // Close the interval: averages are taken and min/max restart in this same frame.
        since = ts - last_avg_mark;
        if (since >= avg_interval) begin
          last_avg_mark = ts;
          mean_rate = RateW'(rate_sum / SumW'(frame_count));
          mean_ticks = TickW'(ticks_sum / SumW'(frame_count));
          rate_sum = '0;
          ticks_sum = '0;
          frame_count = '0;
          lowest_rate = '1;
          highest_rate = '0;
        end
        want.draws = draw_tally;
        want.ticks = delta;
        want.ticks_avg = mean_ticks;
        want.rate = rate;
        want.rate_min = lowest_rate;
        want.rate_max = highest_rate;
        want.rate_avg = mean_rate;
        frames_q.push_back(want);
      end
      default: ;
    endcase
  endtask

  // Watch the configuration port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_stats_t got;
    frame_stats_t want;
    if (!rst_ni) begin
      tick_rate = TickRateReset;
      avg_interval = AvgIntervalReset;
      events_on = 1'b1;
      last_mark = '0;
      last_avg_mark = '0;
      draw_tally = '0;
      lowest_rate = '1;
      highest_rate = '0;
      mean_rate = '0;
      rate_sum = '0;
      ticks_sum = '0;
      frame_count = '0;
      mean_ticks = '0;
      frames_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_TICK_RATE:    tick_rate = pwdata[RateW-1:0];
          REG_AVG_INTERVAL: avg_interval = pwdata[TickW-1:0];
          REG_EVENTS_EN:    events_on = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) track_word(mode_i, timestamp_i, draw_amount_i);
      if (out_valid_o && !out_stall_i) begin
        got.draws = draw_total_o;
        got.ticks = frame_ticks_o;
        got.ticks_avg = frame_ticks_avg_o;
        got.rate = rate_o;
        got.rate_min = rate_min_o;
        got.rate_max = rate_max_o;
        got.rate_avg = rate_avg_o;
        if (frames_q.size() == 0) begin
          report_mismatch("result word with nothing expected (frame_ticks)", got.ticks, '0);
        end else begin
          want = frames_q.pop_front();
          if (got.draws !== want.draws) report_mismatch("draw_total", got.draws, want.draws);
          if (got.ticks !== want.ticks) report_mismatch("frame_ticks", got.ticks, want.ticks);
          if (got.ticks_avg !== want.ticks_avg)
            report_mismatch("frame_ticks_avg", got.ticks_avg, want.ticks_avg);
          if (got.rate !== want.rate)
            report_mismatch("rate", 32'(got.rate), 32'(want.rate));
          if (got.rate_min !== want.rate_min)
            report_mismatch("rate_min", 32'(got.rate_min), 32'(want.rate_min));
          if (got.rate_max !== want.rate_max)
            report_mismatch("rate_max", 32'(got.rate_max), 32'(want.rate_max));
          if (got.rate_avg !== want.rate_avg)
            report_mismatch("rate_avg", 32'(got.rate_avg), 32'(want.rate_avg));
        end
      end
    end
    waiting_o = frames_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame rate statistics monitor: clock, reset, stimulus and verdict.
module tb;
  import frsm_pkg::*;

  localparam int SumW = SumWidthDef;
  localparam int NumPhases = 8;
  localparam int PhaseItems = 100;
  // Idle cycles allowed after the last result before the registers may change.
  localparam int SettleCycles = 3 * SumW + 50;
  localparam int StallLimit = 5000;
  // Mode value with no meaning; the block must ignore such words.
  localparam logic [1:0] ModeSpare = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        mode_i;
  logic [TickW-1:0]  timestamp_i;
  logic [AmtW-1:0]   draw_amount_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DrawW-1:0]  draw_total_o;
  logic [TickW-1:0]  frame_ticks_o;
  logic [TickW-1:0]  frame_ticks_avg_o;
  logic [RateW-1:0]  rate_o;
  logic [RateW-1:0]  rate_min_o;
  logic [RateW-1:0]  rate_max_o;
  logic [RateW-1:0]  rate_avg_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int                errors;
  int                waiting;
  int                idle_cycles;
  bit                calm;
  bit                events_on;

  frame_rate_statistics_monitor #(
    .SUM_WIDTH(SumW)
  ) i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .mode_i, .timestamp_i, .draw_amount_i,
    .out_valid_o, .out_stall_i, .draw_total_o, .frame_ticks_o, .frame_ticks_avg_o,
    .rate_o, .rate_min_o, .rate_max_o, .rate_avg_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  frsm_stats_checker #(
    .SumW(SumW)
  ) i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .mode_i, .timestamp_i, .draw_amount_i,
    .out_valid_o, .out_stall_i, .draw_total_o, .frame_ticks_o, .frame_ticks_avg_o,
    .rate_o, .rate_min_o, .rate_max_o, .rate_avg_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .waiting_o(waiting)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long; none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Offer one input word, starting and ending at a falling edge.
  task automatic send_word(logic [1:0] m, logic [TickW-1:0] ts, logic [AmtW-1:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = m;
    timestamp_i = ts;
    draw_amount_i = amt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Let the block drain, then load a full register setting.
  task automatic apply_setting(logic [DataW-1:0] tr, logic [DataW-1:0] iv, bit ev);
    in_valid_i = 1'b0;
    wait (waiting == 0);
    repeat (SettleCycles) @(negedge clk_i);
    write_reg(REG_TICK_RATE, tr);
    write_reg(REG_AVG_INTERVAL, iv);
    write_reg(REG_EVENTS_EN, DataW'(ev));
    events_on = ev;
  endtask

  // Output stall: alternating free and stalled stretches of random length.
  initial begin
    int free_run;
    int stall_run;
    out_stall_i = 1'b0;
    forever begin
      free_run = $urandom_range(0, 99) < 10 ? $urandom_range(20, 200) : $urandom_range(0, 6);
      stall_run = pick_gap();
      out_stall_i = 1'b0;
      repeat (free_run + 1) @(negedge clk_i);
      if (stall_run > 0) begin
        out_stall_i = 1'b1;
        repeat (stall_run) @(negedge clk_i);
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [DataW-1:0] tr_tab[NumPhases];
    logic [DataW-1:0] iv_tab[NumPhases];
    bit               ev_tab[NumPhases];
    logic [TickW-1:0] mark_clock;
    int               done;
    int               r;
    calm = 1'b0;
    events_on = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_FRAME;
    timestamp_i = '0;
    draw_amount_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part on the reset setting: first mark from time zero, draws, wrap-round.
    send_word(MODE_FRAME, 32'd0, 16'd0);
    send_word(MODE_ADD, 32'd0, 16'hFFFF);
    send_word(MODE_ADD, 32'hFFFF_FFFF, 16'd0);
    send_word(MODE_ADD, 32'd0, 16'h1234);
    send_word(MODE_FRAME, 32'd16667, 16'd0);
    send_word(MODE_FRAME, 32'd16667, 16'hFFFF);
    send_word(ModeSpare, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_FRAME, 32'd2000000, 16'd0);
    send_word(MODE_CLEAR, 32'd0, 16'd0);
    send_word(MODE_FRAME, 32'hFFFF_FFFF, 16'd0);
    send_word(MODE_FRAME, 32'd5, 16'd0);
    send_word(MODE_FRAME, 32'h8000_0000, 16'd0);
    // No tick rate, averaging on every mark, draw additions switched off.
    apply_setting(32'd0, 32'd0, 1'b0);
    send_word(MODE_ADD, 32'd0, 16'd100);
    send_word(MODE_FRAME, 32'h8000_0001, 16'd0);
    send_word(MODE_FRAME, 32'h8000_0001, 16'd0);
    // Largest tick rate with the shortest nonzero interval.
    apply_setting(32'h000F_FFFF, 32'd1, 1'b1);
    send_word(MODE_FRAME, 32'h8000_0002, 16'd0);
    send_word(MODE_FRAME, 32'h8000_0003, 16'd0);
    send_word(MODE_FRAME, 32'h8000_0002, 16'd0);
    send_word(MODE_ADD, 32'd0, 16'hFFFF);
    // Longest interval: averaging only when it is met exactly.
    apply_setting(32'd1000000, 32'hFFFF_FFFF, 1'b1);
    send_word(MODE_FRAME, 32'h8000_000C, 16'd0);
    send_word(MODE_FRAME, 32'h8000_0016, 16'd0);
    send_word(MODE_FRAME, 32'h8000_000B, 16'd0);

    // Settings for the random phases, the extremes among them.
    tr_tab = '{32'd1000000, 32'd0, 32'd1, 32'h000F_FFFF, $urandom_range(0, 20'hF_FFFF),
               32'd60, 32'd1000000, $urandom_range(0, 20'hF_FFFF)};
    iv_tab = '{32'd1000000, 32'd0, 32'd1, 32'hFFFF_FFFF, $urandom_range(1, 200000),
               32'd500, 32'd100000, $urandom_range(1, 2000000)};
    ev_tab = '{1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1, 1'b1,
               1'($urandom_range(0, 1))};
    mark_clock = $urandom;

    // Random part: mostly frame marks at display-like spacing, with draws mixed in.
    for (int p = 0; p < NumPhases; p++) begin
      calm = 1'b0;
      apply_setting(tr_tab[p], iv_tab[p], ev_tab[p]);
      calm = (p == 6);
      done = 0;
      while (done < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          r = $urandom_range(0, 99);
          if (r < 55) mark_clock = mark_clock + $urandom_range(1, 40000);
          else if (r < 70) mark_clock = mark_clock + $urandom_range(1, 16);
          else if (r < 88 && r >= 78) mark_clock = $urandom;
          else if (r >= 88) mark_clock = mark_clock - $urandom_range(1, 1000);
          send_word(MODE_FRAME, mark_clock, 16'($urandom));
          done++;
        end else if (r < 86) begin
          send_word(MODE_ADD, $urandom, 16'($urandom));
          if (events_on) done++;
        end else if (r < 93) begin
          send_word(MODE_CLEAR, $urandom, 16'($urandom));
          done++;
        end else begin
          send_word(ModeSpare, $urandom, 16'($urandom));
        end
      end
    end

    // Drain and give the verdict.
    in_valid_i = 1'b0;
    calm = 1'b0;
    wait (waiting == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
